### src/rv64im_decode_execute_macros.svh
// Assertion macros used by the checker file of the decode and execute block.
`ifndef RV64IM_DECODE_EXECUTE_MACROS_SVH
`define RV64IM_DECODE_EXECUTE_MACROS_SVH

// Implication checked at every rising clock edge outside of reset.
`define RVDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Plain condition checked on every beat that the output side takes.
`define RVDE_ASSERT_BEAT(lbl, beat, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (beat) |-> (cond)) \
    else $error(msg);

`endif

### src/rvde_pkg.sv
// Shared types and constants of the RV64IM decode and execute block.
package rvde_pkg;

  localparam int unsigned XLEN      = 64;
  localparam int unsigned DIV_STEPS = 64;

  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG_W  = 7'h3B;
  localparam logic [6:0] OP_IMM_W  = 7'h1B;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_UPPER_PC = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [5:0] T6_SRL  = 6'h00;
  localparam logic [5:0] T6_SRA  = 6'h10;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;

  typedef enum logic [2:0] {
    SEL_ALU, SEL_MUL, SEL_MULH, SEL_MULW, SEL_DIV, SEL_REM, SEL_DIVW
  } res_sel_e;

  // Everything one instruction carries down the pipeline.
  typedef struct packed {
    logic            we;
    logic [4:0]      rd;
    logic [XLEN-1:0] res;
    logic [XLEN-1:0] npc;
    logic            tk;
    logic [1:0]      kind;
    logic [3:0]      bytes;
    logic [XLEN-1:0] addr;
    logic [XLEN-1:0] sdata;
    logic            inv;
    res_sel_e        sel;
    logic [XLEN-1:0] mres;
    logic [XLEN-1:0] rem;
    logic [XLEN-1:0] quo;
    logic [XLEN-1:0] dvs;
    logic [XLEN-1:0] dvd;
    logic            qneg;
    logic            rneg;
    logic            dzero;
    logic            ovf;
  } pipe_t;

  function automatic logic [XLEN-1:0] sx32(input logic [XLEN-1:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

endpackage

### src/rvde_in_if.sv
// Input channel: instruction word, PC and source operands.
interface rvde_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;
  logic [63:0] pc_value;
  logic [63:0] src1_value;
  logic [63:0] src2_value;

  modport source (output valid, instruction, pc_value, src1_value, src2_value, input ready);
  modport sink (input valid, instruction, pc_value, src1_value, src2_value, output ready);
endinterface

### src/rvde_out_if.sv
// Output channel: register write, next PC and memory request.
interface rvde_out_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [4:0]  dest_index;
  logic [63:0] result_value;
  logic [63:0] next_pc;
  logic        taken;
  logic [1:0]  mem_kind;
  logic [3:0]  mem_bytes;
  logic [63:0] mem_address;
  logic [63:0] store_data;
  logic        invalid;

  modport source (output valid, write_enable, dest_index, result_value, next_pc, taken,
                  mem_kind, mem_bytes, mem_address, store_data, invalid, input ready);
  modport sink (input valid, write_enable, dest_index, result_value, next_pc, taken,
                mem_kind, mem_bytes, mem_address, store_data, invalid, output ready);
endinterface

### src/rv64im_decode_execute.sv
// Pipelined RV64IM decode and execute unit.
// One instruction is accepted per cycle unless stalled, and each passes from input beat to
// output beat through one decode stage, 64 stages of a radix-2 divider (one quotient bit each),
// and the output register. All instructions pass through the same fixed-length pipeline, so
// results leave in order; the 64-bit multiply runs in the first three divider stages as 32x32
// partial products. Each stage holds when the next is full and stalled, so bubbles close up.
module rv64im_decode_execute (
  input  logic clk_i,
  input  logic rst_ni,
  rvde_in_if.sink    in_i,
  rvde_out_if.source out_o
);
  import rvde_pkg::*;

  localparam int unsigned NST = DIV_STEPS + 1;

  pipe_t             st_q [NST];
  pipe_t             st_d [NST];
  pipe_t             dec_d;
  logic [NST-1:0]    v_q;
  logic [NST:0]      en;
  pipe_t             o_q, o_d;
  logic              ov_q;

  // Multiplier side pipeline, aligned with stages zero to two.
  logic [XLEN-1:0] ma_q, mb_q;
  logic [XLEN-1:0] p00_q, p01_q, p10_q, p11_q, corr1_q;
  logic [XLEN-1:0] lo_q, hi_raw_q, corr2_q;
  logic [XLEN-1:0] mid_s;

  // Stall chain: a stage moves when it is empty or its successor moves.
  always_comb begin
    en[NST] = !ov_q || out_o.ready;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end
  assign in_i.ready = en[0];

  // Decode, and combinational execute of the ALU, memory address and branch instructions.
  always_comb begin
    logic [31:0]     ins;
    logic [XLEN-1:0] pc, a, b, immi, imms, immb, immu, immj, da, db, pc4;
    logic [6:0]      op, f7;
    logic [4:0]      rd;
    logic [2:0]      f3;
    logic [5:0]      top6, sh6;
    logic [4:0]      sh5;
    logic            wr, lt, cond, isw;
    pipe_t           p;
    ins  = in_i.instruction;
    pc   = in_i.pc_value;
    a    = in_i.src1_value;
    b    = in_i.src2_value;
    op   = ins[6:0];
    rd   = ins[11:7];
    f3   = ins[14:12];
    f7   = ins[31:25];
    top6 = ins[31:26];
    sh6  = ins[25:20];
    sh5  = ins[24:20];
    immi = {{52{ins[31]}}, ins[31:20]};
    imms = {{52{ins[31]}}, ins[31:25], ins[11:7]};
    immb = {{51{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    immu = {{32{ins[31]}}, ins[31:12], 12'b0};
    immj = {{43{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    pc4  = pc + 64'd4;
    lt   = $signed(a) < $signed(b);
    cond = 1'b0;
    wr   = 1'b0;
    p    = '0;
    p.sel = SEL_ALU;
    p.npc = pc4;
    unique case (op)
      OP_REG: begin
        wr = 1'b1;
        if (f7 == F7_BASE) begin
          case (f3)
            3'd0: p.res = a + b;
            3'd1: p.res = a << b[5:0];
            3'd2: p.res = {63'b0, lt};
            3'd4: p.res = a ^ b;
            3'd5: p.res = a >> b[5:0];
            3'd6: p.res = a | b;
            3'd7: p.res = a & b;
            default: p.inv = 1'b1;
          endcase
        end else if (f7 == F7_ALT && f3 == 3'd0) begin
          p.res = a - b;
        end else if (f7 == F7_ALT && f3 == 3'd5) begin
          p.res = $unsigned($signed(a) >>> b[5:0]);
        end else if (f7 == F7_MULDIV) begin
          case (f3)
            3'd0: p.sel = SEL_MUL;
            3'd1: p.sel = SEL_MULH;
            3'd4: p.sel = SEL_DIV;
            3'd6: p.sel = SEL_REM;
            default: p.inv = 1'b1;
          endcase
        end else begin
          p.inv = 1'b1;
        end
      end
      OP_IMM: begin
        wr = 1'b1;
        case (f3)
          3'd0: p.res = a + immi;
          3'd1: begin
            if (top6 == T6_SRL) p.res = a << sh6;
            else p.inv = 1'b1;
          end
          3'd2: p.res = {63'b0, $signed(a) < $signed(immi)};
          3'd4: p.res = a ^ immi;
          3'd5: begin
            if (top6 == T6_SRL) p.res = a >> sh6;
            else if (top6 == T6_SRA) p.res = $unsigned($signed(a) >>> sh6);
            else p.inv = 1'b1;
          end
          3'd6: p.res = a | immi;
          3'd7: p.res = a & immi;
          default: p.inv = 1'b1;
        endcase
      end
      OP_REG_W: begin
        wr = 1'b1;
        if (f7 == F7_BASE && f3 == 3'd0) p.res = sx32(a + b);
        else if (f7 == F7_ALT && f3 == 3'd0) p.res = sx32(a - b);
        else if (f7 == F7_MULDIV && f3 == 3'd0) p.sel = SEL_MULW;
        else if (f7 == F7_MULDIV && f3 == 3'd4) p.sel = SEL_DIVW;
        else p.inv = 1'b1;
      end
      OP_IMM_W: begin
        wr = 1'b1;
        if (f3 == 3'd0) p.res = sx32(a + immi);
        else if (f3 == 3'd1 && f7 == F7_BASE) p.res = sx32({32'b0, a[31:0] << sh5});
        else if (f3 == 3'd5 && f7 == F7_BASE) p.res = sx32({32'b0, a[31:0] >> sh5});
        else p.inv = 1'b1;
      end
      OP_LOAD: begin
        if (!f3[2]) begin
          wr      = 1'b1;
          p.kind  = MEM_LOAD;
          p.bytes = 4'd1 << f3[1:0];
          p.addr  = a + immi;
        end else begin
          p.inv = 1'b1;
        end
      end
      OP_STORE: begin
        if (!f3[2]) begin
          p.kind  = MEM_STORE;
          p.bytes = 4'd1 << f3[1:0];
          p.addr  = a + imms;
          p.sdata = b;
        end else begin
          p.inv = 1'b1;
        end
      end
      OP_BRANCH: begin
        case (f3)
          3'd0: cond = (a == b);
          3'd1: cond = (a != b);
          3'd4: cond = lt;
          3'd5: cond = !lt;
          default: p.inv = 1'b1;
        endcase
        if (cond) begin
          p.tk  = 1'b1;
          p.npc = pc + immb;
        end
      end
      OP_LUI: begin
        wr = 1'b1;
        p.res = immu;
      end
      OP_UPPER_PC: begin
        wr = 1'b1;
        p.res = pc + immu;
      end
      OP_JAL: begin
        wr = 1'b1;
        p.res = pc4;
        p.tk = 1'b1;
        p.npc = pc + immj;
      end
      OP_JALR: begin
        if (f3 == 3'd0) begin
          wr = 1'b1;
          p.res = pc4;
          p.tk = 1'b1;
          p.npc = (a + immi) & ~64'd1;
        end else begin
          p.inv = 1'b1;
        end
      end
      default: p.inv = 1'b1;
    endcase
    // Divider operands as magnitudes with the sign fixups noted.
    isw     = (p.sel == SEL_DIVW);
    da      = isw ? sx32(a) : a;
    db      = isw ? sx32(b) : b;
    p.dvd   = da;
    p.qneg  = da[63] ^ db[63];
    p.rneg  = da[63];
    p.dzero = (db == '0);
    p.ovf   = (da == {1'b1, 63'b0}) && (db == '1);
    p.quo   = da[63] ? -da : da;
    p.dvs   = db[63] ? -db : db;
    p.rem   = '0;
    if (p.inv) begin
      wr = 1'b0;
      p.sel = SEL_ALU;
      p.res = '0;
      p.tk = 1'b0;
      p.npc = pc4;
      p.kind = MEM_NONE;
      p.bytes = '0;
      p.addr = '0;
      p.sdata = '0;
    end
    if (p.kind == MEM_LOAD) p.res = '0;
    if (!wr) p.res = '0;
    p.we = wr && (rd != 5'd0);
    p.rd = p.we ? rd : 5'd0;
    dec_d = p;
  end

  // Stage zero takes the decoded beat; each later stage does one restoring division step,
  // and the multiply result joins in stage three.
  always_comb begin
    st_d[0] = dec_d;
    for (int k = 1; k < NST; k++) begin
      logic [XLEN:0] t;
      logic          ge;
      st_d[k] = st_q[k-1];
      t  = {st_q[k-1].rem, st_q[k-1].quo[XLEN-1]};
      ge = (t >= {1'b0, st_q[k-1].dvs});
      st_d[k].rem = ge ? t[XLEN-1:0] - st_q[k-1].dvs : t[XLEN-1:0];
      st_d[k].quo = {st_q[k-1].quo[XLEN-2:0], ge};
      if (k == 3) begin
        case (st_q[k-1].sel)
          SEL_MULH: st_d[k].mres = hi_raw_q - corr2_q;
          SEL_MULW: st_d[k].mres = sx32(lo_q);
          default:  st_d[k].mres = lo_q;
        endcase
      end
    end
  end

  // Pipeline payload registers.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NST; k++) begin
      if (en[k]) st_q[k] <= st_d[k];
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      ov_q <= 1'b0;
    end else begin
      if (en[0]) v_q[0] <= in_i.valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
      if (en[NST]) ov_q <= v_q[NST-1];
    end
  end

  // Multiplier: partial products, then the sums, then the signed correction.
  assign mid_s = {32'b0, p00_q[63:32]} + {32'b0, p01_q[31:0]} + {32'b0, p10_q[31:0]};
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ma_q <= in_i.src1_value;
      mb_q <= in_i.src2_value;
    end
    if (en[1]) begin
      p00_q   <= ma_q[31:0] * mb_q[31:0];
      p01_q   <= ma_q[31:0] * mb_q[63:32];
      p10_q   <= ma_q[63:32] * mb_q[31:0];
      p11_q   <= ma_q[63:32] * mb_q[63:32];
      corr1_q <= (ma_q[63] ? mb_q : '0) + (mb_q[63] ? ma_q : '0);
    end
    if (en[2]) begin
      lo_q     <= {mid_s[31:0], p00_q[31:0]};
      hi_raw_q <= p11_q + {32'b0, p01_q[63:32]} + {32'b0, p10_q[63:32]} +
                  {32'b0, mid_s[63:32]};
      corr2_q  <= corr1_q;
    end
  end

  // Final result selection with the division special cases.
  always_comb begin
    pipe_t           s;
    logic [XLEN-1:0] q;
    s = st_q[NST-1];
    o_d = s;
    if (s.dzero) q = '1;
    else if (s.ovf) q = s.dvd;
    else q = s.qneg ? -s.quo : s.quo;
    case (s.sel)
      SEL_MUL, SEL_MULH, SEL_MULW: o_d.res = s.mres;
      SEL_DIV: o_d.res = q;
      SEL_DIVW: o_d.res = sx32(q);
      SEL_REM: begin
        if (s.dzero) o_d.res = s.dvd;
        else if (s.ovf) o_d.res = '0;
        else o_d.res = s.rneg ? -s.rem : s.rem;
      end
      default: o_d.res = s.res;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[NST]) o_q <= o_d;
  end

  assign out_o.valid        = ov_q;
  assign out_o.write_enable = o_q.we;
  assign out_o.dest_index   = o_q.rd;
  assign out_o.result_value = o_q.res;
  assign out_o.next_pc      = o_q.npc;
  assign out_o.taken        = o_q.tk;
  assign out_o.mem_kind     = o_q.kind;
  assign out_o.mem_bytes    = o_q.bytes;
  assign out_o.mem_address  = o_q.addr;
  assign out_o.store_data   = o_q.sdata;
  assign out_o.invalid      = o_q.inv;

endmodule

### src/rvde_checker.sv
// Port-level checks of the decode and execute block, bound to the top level.
`include "rv64im_decode_execute_macros.svh"

module rvde_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       write_enable_i,
  input logic [4:0] dest_index_i,
  input logic       taken_i,
  input logic [1:0] mem_kind_i,
  input logic [3:0] mem_bytes_i,
  input logic [63:0] mem_address_i,
  input logic       invalid_i
);
  import rvde_pkg::*;

  logic beat;
  logic quiet;
  logic no_mem_fields;
  assign beat = out_valid_i && out_ready_i;
  assign quiet = !write_enable_i && !taken_i && (mem_kind_i == MEM_NONE);
  assign no_mem_fields = (mem_bytes_i == 4'd0) && (mem_address_i == 64'd0);

  // A waiting result stays until it is taken.
  `RVDE_ASSERT(a_hold, out_valid_i && !out_ready_i |=> out_valid_i, "output beat dropped")
  // Invalid instructions request nothing.
  `RVDE_ASSERT_BEAT(a_inv, beat && invalid_i, quiet, "invalid instruction has side effects")
  // Writes never target x0.
  `RVDE_ASSERT_BEAT(a_x0, beat && write_enable_i, dest_index_i != 5'd0, "write to x0")
  // No memory request means no size or address.
  `RVDE_ASSERT_BEAT(a_mem, beat && mem_kind_i == MEM_NONE, no_mem_fields, "stray memory fields")

endmodule

bind rv64im_decode_execute rvde_checker u_rvde_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .write_enable_i (out_o.write_enable),
  .dest_index_i   (out_o.dest_index),
  .taken_i        (out_o.taken),
  .mem_kind_i     (out_o.mem_kind),
  .mem_bytes_i    (out_o.mem_bytes),
  .mem_address_i  (out_o.mem_address),
  .invalid_i      (out_o.invalid)
);
